// ----- rtl/core/cancellable_timer_queue_macros.svh -----
// assertion macros shared by the timer queue rtl
// expects clk and rst_n in the scope of the module that uses them
`ifndef CANCELLABLE_TIMER_QUEUE_MACROS_SVH
`define CANCELLABLE_TIMER_QUEUE_MACROS_SVH

// same-cycle implication, off while reset is low
`define CTQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is low
`define CTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/ctq_pkg.sv -----
// types, codes and fixed widths for the timer queue
// no dependencies
package ctq_pkg;

  localparam int ID_W        = 32;
  localparam int TIME_W      = 48;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // input opcodes
  localparam logic [1:0] OP_SCHEDULE = 2'd0;
  localparam logic [1:0] OP_CANCEL   = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_ACK       = 2'd0;
  localparam logic [1:0] KIND_FIRED     = 2'd1;
  localparam logic [1:0] KIND_IDLE_TICK = 2'd2;

  // acknowledgement status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_REPLACED = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;
  localparam logic [1:0] STATUS_ABSENT   = 2'd3;

  // one queue entry
  typedef struct packed {
    logic [TIME_W-1:0] fire_t;
    logic [ID_W-1:0]   id;
    logic              active;
  } ctq_entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic              clear_en;
    logic              insert_en;
    logic              pop_en;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] fire_t;
  } ctq_cmd_t;

endpackage

// ----- rtl/core/ctq_in_if.sv -----
// request channel of the timer queue: valid/ready plus request word
// depends on ctq_pkg
interface ctq_in_if import ctq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [ID_W-1:0]   alarm_id;
  logic [TIME_W-1:0] fire_time;
  logic [TIME_W-1:0] now_time;

  modport source (output valid, output op, output alarm_id, output fire_time,
                  output now_time, input ready);
  modport sink   (input valid, input op, input alarm_id, input fire_time,
                  input now_time, output ready);
endinterface

// ----- rtl/core/ctq_out_if.sv -----
// result channel of the timer queue: valid/ready plus result word
// depends on ctq_pkg
interface ctq_out_if import ctq_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      kind;
  logic [ID_W-1:0] fired_id;
  logic [1:0]      status;
  logic            last;

  modport source (output valid, output kind, output fired_id, output status,
                  output last, input ready);
  modport sink   (input valid, input kind, input fired_id, input status,
                  input last, output ready);
endinterface

// ----- rtl/core/ctq_cell.sv -----
// one slot of the sorted alarm chain: holds an entry, clears on id match,
// takes its lower neighbor on insert shift and its upper neighbor on pop; uses ctq_pkg
module ctq_cell
  import ctq_pkg::*;
(
  input  logic       clk,
  input  ctq_cmd_t   cmd,
  input  logic       own_occ,
  input  logic       prev_occ,
  input  logic       prev_gt,
  input  ctq_entry_t prev_ent,
  input  ctq_entry_t next_ent,
  output ctq_entry_t ent_o,
  output logic       gt_o,
  output logic       hit_o
);

  ctq_entry_t ent_r;
  ctq_entry_t ent_nxt;
  ctq_entry_t new_ent;

  // id match clears the active mark
  assign hit_o = cmd.clear_en && own_occ && ent_r.active && (ent_r.id == cmd.id);

  always_comb begin
    ent_o = ent_r;
    if (hit_o) begin
      ent_o.active = 1'b0;
    end
  end

  // later than the incoming time: this entry moves up one slot
  assign gt_o = own_occ && (ent_r.fire_t > cmd.fire_t);

  assign new_ent = '{fire_t: cmd.fire_t, id: cmd.id, active: 1'b1};

  // next entry
  always_comb begin
    ent_nxt = ent_o;
    if (cmd.insert_en) begin
      if (prev_gt) begin
        ent_nxt = prev_ent;
      end else if (gt_o || (!own_occ && prev_occ)) begin
        ent_nxt = new_ent;
      end
    end else if (cmd.pop_en) begin
      ent_nxt = next_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ----- rtl/core/cancellable_timer_queue.sv -----
// top level of the cancellable timer queue: chain of ctq_cell slots plus the
// tick sequencer and the result register; uses ctq_pkg, ctq_in_if, ctq_out_if
//
//   channel  dir  handshake          word
//   in_ch    in   valid/ready        op, alarm_id, fire_time, now_time
//   out_ch   out  valid/ready        kind, fired_id, status, last
//
// schedule and cancel finish in the accept cycle: all cells compare and shift
// at once, the ack is in the result register on the next cycle.
// a tick pops due entries one at a time from the chain head, then sends the
// closing result; fired ids leave one per cycle while out_ch takes them.
// reset clears the fill count, sequencer and result valid only; slot contents need none.
// a stalled out_ch holds the result register and stops requests; a tick stops
// popping live entries once a fired id waits behind the held word.
`include "cancellable_timer_queue_macros.svh"

module cancellable_timer_queue
  import ctq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input logic       clk,
  input logic       rst_n,
  ctq_in_if.sink    in_ch,
  ctq_out_if.source out_ch
);

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_TICK
  } state_t;

  state_t            state_r, state_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]   pend_id_r, pend_id_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;

  ctq_cmd_t   cmd;
  ctq_entry_t cell_ent [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_gt;
  logic [QUEUE_DEPTH-1:0] cell_hit;
  logic [QUEUE_DEPTH-1:0] cell_occ;

  logic accept, out_free, full, any_hit;
  logic is_sched, cancel_like, insert_ok, due, pop;
  logic [1:0] ack_status;

  // handshake
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign accept      = in_ch.valid && in_ch.ready;

  // request decode
  assign full        = (occ_r == OCC_W'(QUEUE_DEPTH));
  assign is_sched    = (in_ch.op == OP_SCHEDULE);
  assign cancel_like = (in_ch.op == OP_CANCEL) ||
                       (is_sched && (in_ch.fire_time == '0));
  assign insert_ok   = is_sched && (in_ch.fire_time != '0) && !full;
  assign any_hit     = |cell_hit;

  // tick: head entry due and result budget left
  assign due = (state_r == ST_TICK) && (occ_r != '0) &&
               (cell_ent[0].fire_t <= now_r) && (cnt_r != CNT_W'(MAX_RESULTS));
  assign pop = due && !(cell_ent[0].active && pend_v_r && !out_free);

  // broadcast command
  always_comb begin
    cmd.clear_en  = accept && (cancel_like || insert_ok);
    cmd.insert_en = accept && insert_ok;
    cmd.pop_en    = pop;
    cmd.id        = in_ch.alarm_id;
    cmd.fire_t    = in_ch.fire_time;
  end

  // the chain of slots
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    ctq_entry_t prev_ent, next_ent;
    logic       prev_gt, prev_occ;

    assign cell_occ[i] = (OCC_W'(i) < occ_r);

    if (i == 0) begin : g_head
      assign prev_ent = cell_ent[i];
      assign prev_gt  = 1'b0;
      assign prev_occ = 1'b1;
    end else begin : g_body
      assign prev_ent = cell_ent[i-1];
      assign prev_gt  = cell_gt[i-1];
      assign prev_occ = cell_occ[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_ent = cell_ent[i];
    end else begin : g_mid
      assign next_ent = cell_ent[i+1];
    end

    ctq_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .own_occ  (cell_occ[i]),
      .prev_occ (prev_occ),
      .prev_gt  (prev_gt),
      .prev_ent (prev_ent),
      .next_ent (next_ent),
      .ent_o    (cell_ent[i]),
      .gt_o     (cell_gt[i]),
      .hit_o    (cell_hit[i])
    );
  end

  // ack status
  always_comb begin
    if (cancel_like) begin
      ack_status = any_hit ? STATUS_OK : STATUS_ABSENT;
    end else if (full) begin
      ack_status = STATUS_FULL;
    end else begin
      ack_status = any_hit ? STATUS_REPLACED : STATUS_OK;
    end
  end

  // sequencer and result register next values
  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    now_nxt        = now_r;
    cnt_nxt        = cnt_r;
    pend_v_nxt     = pend_v_r;
    pend_id_nxt    = pend_id_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_kind_nxt   = out_kind_r;
    out_id_nxt     = out_id_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_ch.op)
            OP_SCHEDULE, OP_CANCEL: begin
              out_valid_nxt  = 1'b1;
              out_kind_nxt   = KIND_ACK;
              out_id_nxt     = in_ch.alarm_id;
              out_status_nxt = ack_status;
              out_last_nxt   = 1'b1;
              if (insert_ok) begin
                occ_nxt = occ_r + OCC_W'(1);
              end
            end
            OP_TICK: begin
              state_nxt  = ST_TICK;
              now_nxt    = in_ch.now_time;
              cnt_nxt    = '0;
              pend_v_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_TICK: begin
        if (due) begin
          if (pop) begin
            occ_nxt = occ_r - OCC_W'(1);
            if (cell_ent[0].active) begin
              // the held word is not the last one: send it on
              if (pend_v_r) begin
                out_valid_nxt  = 1'b1;
                out_kind_nxt   = KIND_FIRED;
                out_id_nxt     = pend_id_r;
                out_status_nxt = STATUS_OK;
                out_last_nxt   = 1'b0;
              end
              pend_v_nxt  = 1'b1;
              pend_id_nxt = cell_ent[0].id;
              cnt_nxt     = cnt_r + CNT_W'(1);
            end
          end
        end else if (out_free) begin
          // closing word of the tick
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = pend_v_r ? KIND_FIRED : KIND_IDLE_TICK;
          out_id_nxt     = pend_v_r ? pend_id_r : '0;
          out_status_nxt = STATUS_OK;
          out_last_nxt   = 1'b1;
          pend_v_nxt     = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    now_r        <= now_nxt;
    pend_id_r    <= pend_id_nxt;
    out_kind_r   <= out_kind_nxt;
    out_id_r     <= out_id_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = out_kind_r;
  assign out_ch.fired_id = out_id_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.last     = out_last_r;

  // checks
  `CTQ_ASSERT_NOW(a_occ_bound, 1'b1, occ_r <= OCC_W'(QUEUE_DEPTH), "fill count above depth")
  `CTQ_ASSERT_NOW(a_pop_nonempty, pop, occ_r != '0 && !cmd.insert_en, "pop from empty chain")
  `CTQ_ASSERT_NEXT(a_insert_count, cmd.insert_en, occ_r == $past(occ_r) + OCC_W'(1), "insert lost")
  `CTQ_ASSERT_NEXT(a_pop_count, pop, occ_r == $past(occ_r) - OCC_W'(1), "pop not counted")
  `CTQ_ASSERT_NOW(a_budget, 1'b1, cnt_r <= CNT_W'(MAX_RESULTS), "tick result budget overrun")

endmodule

// ----- sim/cancellable_timer_queue_tb.sv -----
// self-checking testbench for cancellable_timer_queue: directed table, then random traffic
// depends on ctq_pkg, ctq_in_if, ctq_out_if and the cancellable_timer_queue rtl
module cancellable_timer_queue_tb;
  import ctq_pkg::*;

  localparam int QUEUE_DEPTH    = 32;
  localparam int TOTAL_ITEMS    = 450;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int NUM_ROWS       = 22;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // one result word as the block emits it
  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] fired_id;
    logic [1:0]      status;
    logic            last;
  } alarm_result_t;

  // one row of the directed table; typed rows carry their single expected word
  typedef struct packed {
    logic [1:0]        op;
    logic [ID_W-1:0]   alarm_id;
    logic [TIME_W-1:0] fire_time;
    logic [TIME_W-1:0] now_time;
    logic              typed;
    logic [1:0]        kind;
    logic [ID_W-1:0]   fired_id;
    logic [1:0]        status;
  } stim_row_t;

  logic clk;
  logic rst_n;

  ctq_in_if  in_if ();
  ctq_out_if out_if ();

  cancellable_timer_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if.sink),
    .out_ch(out_if.source)
  );

  // predictor state and the words still owed by the block
  ctq_entry_t        alarm_q[$];
  alarm_result_t     awaited_results[$];
  logic [TIME_W-1:0] alarm_clock;
  int                items_accepted;
  int                mismatch_count;
  int                idle_cycles;
  int                burst_left;
  bit                hold_req;

  stim_row_t directed_rows [NUM_ROWS] = '{
    // empty queue after reset
    '{OP_TICK,     32'd0,          48'd0,    48'd0,    1'b1, KIND_IDLE_TICK, 32'd0,  STATUS_OK},
    '{OP_CANCEL,   32'd5,          48'd0,    48'd0,    1'b1, KIND_ACK,       32'd5,  STATUS_ABSENT},
    '{OP_SCHEDULE, 32'd0,          48'd0,    48'd0,    1'b1, KIND_ACK,       32'd0,  STATUS_ABSENT},
    // extremes, replacement, equal times
    '{OP_SCHEDULE, 32'hFFFF_FFFF,  TIME_MAX, 48'd0,    1'b1, KIND_ACK, 32'hFFFF_FFFF, STATUS_OK},
    '{OP_SCHEDULE, 32'd1,          48'd100,  48'd0,    1'b1, KIND_ACK,       32'd1,  STATUS_OK},
    '{OP_SCHEDULE, 32'd1,          48'd50,   48'd0,    1'b1, KIND_ACK,       32'd1,  STATUS_REPLACED},
    '{OP_SCHEDULE, 32'd2,          48'd50,   48'd0,    1'b1, KIND_ACK,       32'd2,  STATUS_OK},
    '{OP_SCHEDULE, 32'd3,          48'd50,   48'd0,    1'b1, KIND_ACK,       32'd3,  STATUS_OK},
    '{OP_SCHEDULE, 32'd4,          48'd1,    48'd0,    1'b1, KIND_ACK,       32'd4,  STATUS_OK},
    // cancel and schedule-at-zero
    '{OP_CANCEL,   32'd2,          48'd0,    48'd0,    1'b1, KIND_ACK,       32'd2,  STATUS_OK},
    '{OP_SCHEDULE, 32'd3,          48'd0,    48'd0,    1'b1, KIND_ACK,       32'd3,  STATUS_OK},
    '{OP_CANCEL,   32'd3,          48'd0,    48'd0,    1'b1, KIND_ACK,       32'd3,  STATUS_ABSENT},
    // ticks, unused opcode
    '{OP_TICK,     32'd0,          48'd0,    48'd0,    1'b1, KIND_IDLE_TICK, 32'd0,  STATUS_OK},
    '{OP_UNUSED,   32'hFFFF_FFFF,  TIME_MAX, TIME_MAX, 1'b0, KIND_ACK,       32'd0,  STATUS_OK},
    '{OP_TICK,     32'd0,          48'd0,    48'd1,    1'b1, KIND_FIRED,     32'd4,  STATUS_OK},
    '{OP_TICK,     32'd0,          48'd0,    48'd50,   1'b0, KIND_ACK,       32'd0,  STATUS_OK},
    '{OP_TICK,     32'd0,          48'd0,    48'd100,  1'b0, KIND_ACK,       32'd0,  STATUS_OK},
    '{OP_SCHEDULE, 32'h8000_0001,  48'h8000_0000_0000, 48'd0, 1'b0, KIND_ACK, 32'd0, STATUS_OK},
    '{OP_SCHEDULE, 32'd6,          48'd200,  48'd0,    1'b0, KIND_ACK,       32'd0,  STATUS_OK},
    '{OP_TICK,     32'd0,          48'd0,    TIME_MAX, 1'b0, KIND_ACK,       32'd0,  STATUS_OK},
    '{OP_TICK,     32'd0,          48'd0,    TIME_MAX, 1'b1, KIND_IDLE_TICK, 32'd0,  STATUS_OK},
    '{OP_TICK,     32'h7FFF_FFFF,  48'd0,    48'd5,    1'b1, KIND_IDLE_TICK, 32'd0,  STATUS_OK}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mismatch reporting
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch: %s got %0h want %0h (after %0d items)", what, got, want,
             items_accepted);
    mismatch_count++;
  endtask

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[TIME_W-1:0];
  endfunction

  // clear the active mark of every live alarm with this id
  function automatic bit cancel_alarm(logic [ID_W-1:0] id);
    bit         hit;
    ctq_entry_t e;
    hit = 1'b0;
    for (int i = 0; i < alarm_q.size(); i++) begin
      e = alarm_q[i];
      if (e.active && e.id == id) begin
        e.active = 1'b0;
        alarm_q[i] = e;
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic void owe_word(logic [1:0] kind, logic [ID_W-1:0] id, logic [1:0] status);
    alarm_result_t r;
    r = '{kind, id, status, 1'b0};
    awaited_results.push_back(r);
  endfunction

  // timer queue behavior for one request word; appends the words it causes
  function automatic void step_alarm_queue(logic [1:0] op, logic [ID_W-1:0] id,
                                           logic [TIME_W-1:0] ft, logic [TIME_W-1:0] now_t);
    int            base;
    int            pos;
    int            fired;
    bit            hit;
    ctq_entry_t    e;
    alarm_result_t r;
    base = awaited_results.size();
    case (op)
      OP_SCHEDULE, OP_CANCEL: begin
        if (op == OP_CANCEL || ft == '0) begin
          hit = cancel_alarm(id);
          owe_word(KIND_ACK, id, hit ? STATUS_OK : STATUS_ABSENT);
        end else if (alarm_q.size() >= QUEUE_DEPTH) begin
          owe_word(KIND_ACK, id, STATUS_FULL);
        end else begin
          hit = cancel_alarm(id);
          // behind every entry with the same or an earlier time
          pos = alarm_q.size();
          while (pos > 0 && alarm_q[pos-1].fire_t > ft) pos--;
          e = '{ft, id, 1'b1};
          alarm_q.insert(pos, e);
          owe_word(KIND_ACK, id, hit ? STATUS_REPLACED : STATUS_OK);
        end
      end
      OP_TICK: begin
        fired = 0;
        while (alarm_q.size() > 0 && fired < MAX_RESULTS && alarm_q[0].fire_t <= now_t) begin
          e = alarm_q.pop_front();
          if (e.active) begin
            owe_word(KIND_FIRED, e.id, STATUS_OK);
            fired++;
          end
        end
        if (fired == 0) owe_word(KIND_IDLE_TICK, '0, STATUS_OK);
      end
      default: ;
    endcase
    if (awaited_results.size() > base) begin
      r = awaited_results.pop_back();
      r.last = 1'b1;
      awaited_results.push_back(r);
    end
  endfunction

  // offer one request word in bursts with gaps; predict once it is taken
  task automatic offer(logic [1:0] op, logic [ID_W-1:0] id, logic [TIME_W-1:0] ft,
                       logic [TIME_W-1:0] now_t, bit typed = 1'b0,
                       alarm_result_t want = '0);
    int base;
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 24);
    end
    in_if.valid     <= 1'b1;
    in_if.op        <= op;
    in_if.alarm_id  <= id;
    in_if.fire_time <= ft;
    in_if.now_time  <= now_t;
    do @(posedge clk); while (!in_if.ready);
    burst_left--;
    base = awaited_results.size();
    step_alarm_queue(op, id, ft, now_t);
    if (typed) begin
      while (awaited_results.size() > base) void'(awaited_results.pop_back());
      awaited_results.push_back(want);
    end
    if (op != OP_UNUSED) items_accepted++;
  endtask

  // sender pause until every owed word has come back
  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // overfill the queue, then one tick that fires the lot
  task automatic fill_burst();
    logic [ID_W-1:0] base_id;
    base_id = $urandom();
    for (int i = 0; i < QUEUE_DEPTH + 2; i++)
      offer(OP_SCHEDULE, base_id + ID_W'(i),
            alarm_clock + TIME_W'($urandom_range(1, 1000)), '0);
    alarm_clock += TIME_W'(1000);
    offer(OP_TICK, '0, '0, alarm_clock);
  endtask

  // receiver: stall patterns drawn at random from four, long hold on request
  initial begin : receiver
    int cyc;
    int mode;
    cyc  = 0;
    mode = 0;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (cyc % 64 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= (cyc % 4 != 3);
          2: out_if.ready <= ($urandom_range(0, 1) == 1);
          default: out_if.ready <= (cyc % 16 < 4);
        endcase
        cyc++;
        @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    alarm_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("word with nothing owed",
                        {out_if.kind, out_if.fired_id, out_if.status, out_if.last}, '0);
      end else begin
        want = awaited_results.pop_front();
        if (out_if.kind !== want.kind) report_mismatch("kind", out_if.kind, want.kind);
        if (out_if.fired_id !== want.fired_id)
          report_mismatch("fired_id", out_if.fired_id, want.fired_id);
        if (out_if.status !== want.status)
          report_mismatch("status", out_if.status, want.status);
        if (out_if.last !== want.last) report_mismatch("last", out_if.last, want.last);
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", idle_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int               pick;
    int               seq_len;
    int               r;
    logic [1:0]       op;
    logic [TIME_W-1:0] ft;
    alarm_result_t    want;
    items_accepted = 0;
    mismatch_count = 0;
    burst_left     = 0;
    hold_req       = 1'b0;
    alarm_clock    = '0;
    idle_cycles    = 0;
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.op        <= OP_SCHEDULE;
    in_if.alarm_id  <= '0;
    in_if.fire_time <= '0;
    in_if.now_time  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      want = '{directed_rows[i].kind, directed_rows[i].fired_id, directed_rows[i].status,
               1'b1};
      offer(directed_rows[i].op, directed_rows[i].alarm_id, directed_rows[i].fire_time,
            directed_rows[i].now_time, directed_rows[i].typed, want);
    end
    alarm_clock = TIME_W'(1000);

    // first overfill under a long receiver hold, then a full drain
    hold_req = 1'b1;
    fill_burst();
    wait_for_drain();

    // random sequences
    while (items_accepted < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 7) begin
        if ($urandom_range(0, 1) == 1) hold_req = 1'b1;
        fill_burst();
      end else if (pick < 20) begin
        // noise word, any opcode and any field value
        offer(2'($urandom_range(0, 3)), $urandom(), rand_time(), rand_time());
      end else begin
        // schedules and cancels around the current time, closed by a tick
        seq_len = $urandom_range(3, 10);
        for (int k = 0; k < seq_len; k++) begin
          r  = $urandom_range(0, 9);
          op = (r < 2) ? OP_CANCEL : OP_SCHEDULE;
          ft = (r == 2) ? '0 : alarm_clock + TIME_W'($urandom_range(0, 300));
          offer(op, ID_W'($urandom_range(0, 15)), ft, '0);
        end
        alarm_clock += TIME_W'($urandom_range(0, 200));
        offer(OP_TICK, $urandom(), '0, alarm_clock);
      end
      if ($urandom_range(0, 19) == 0) wait_for_drain();
    end

    // let everything owed come back, then settle
    in_if.valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
